@@ src/ifpm_pkg.sv @@
// ----------------------------------------------------------------------------
// ifpm_pkg: shared types, constants and helpers for the pixel to floor map
// Fixed-point formats, calibration coefficient tables and the Q0.15 multiply.
// ----------------------------------------------------------------------------
package ifpm_pkg;

  // field and datapath widths
  localparam int unsigned PIX_W     = 15;  // Q0.15 pixel code
  localparam int unsigned OUT_W     = 20;  // Q3.16 result
  localparam int unsigned NUM_TERMS = 15;  // monomials up to degree four
  localparam int unsigned MONO_W    = 16;  // monomial incl. the 1.0 term
  localparam int unsigned COEF_W    = 24;  // signed Q4.20
  localparam int unsigned PROD_W    = 39;  // |m * c| < 2^38
  localparam int unsigned ACC_W     = 43;  // sum of 15 products
  localparam int unsigned FRAC_DROP = 19;  // Q.35 -> Q.16

  // 1.0 in Q0.15
  localparam logic [MONO_W-1:0] ONE_Q15 = MONO_W'(32768);

  // monomial slots
  localparam int unsigned M_ONE  = 0;
  localparam int unsigned M_U    = 1;
  localparam int unsigned M_V    = 2;
  localparam int unsigned M_U2   = 3;
  localparam int unsigned M_UV   = 4;
  localparam int unsigned M_V2   = 5;
  localparam int unsigned M_U3   = 6;
  localparam int unsigned M_U2V  = 7;
  localparam int unsigned M_UV2  = 8;
  localparam int unsigned M_V3   = 9;
  localparam int unsigned M_U4   = 10;
  localparam int unsigned M_U3V  = 11;
  localparam int unsigned M_U2V2 = 12;
  localparam int unsigned M_UV3  = 13;
  localparam int unsigned M_V4   = 14;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] floor_x;
    logic signed [OUT_W-1:0] floor_y;
  } flr_t;

  typedef logic [NUM_TERMS-1:0][MONO_W-1:0] mono_vec_t;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    acc_t acc_x;
    acc_t acc_y;
  } acc_pair_t;

  // calibration coefficients, Q4.20, in monomial order
  localparam logic signed [COEF_W-1:0] COEF_X [NUM_TERMS] = '{
    24'sd4562513, -24'sd5099498, -24'sd124075, 24'sd1147544, 24'sd509779,
    24'sd148737,  -24'sd702645,  24'sd319760,  -24'sd457400, 24'sd194276,
    -24'sd80497,  -24'sd76440,   -24'sd137682, -24'sd93795,  -24'sd58813
  };

  localparam logic signed [COEF_W-1:0] COEF_Y [NUM_TERMS] = '{
    -24'sd357493, 24'sd547994,   24'sd5148499, -24'sd409106, -24'sd546254,
    -24'sd1146194, 24'sd63086,   24'sd534892,  -24'sd324807, 24'sd581139,
    -24'sd30149,  24'sd53198,    24'sd186978,  24'sd105430,  24'sd116911
  };

  // Q0.15 product, round half up; result always fits in 15 bits
  function automatic logic [PIX_W-1:0] qmul(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [2*PIX_W-1:0] p;
    p = (2*PIX_W)'(a) * (2*PIX_W)'(b) + (2*PIX_W)'(2**(PIX_W-1));
    return p[2*PIX_W-1:PIX_W];
  endfunction

endpackage

@@ src/ifpm_mono.sv @@
// ----------------------------------------------------------------------------
// ifpm_mono: monomial generator
// Four register stages build the 15 Q0.15 monomials of u and v up to total
// degree four, one Q0.15 multiply deep between registers.
// ----------------------------------------------------------------------------
module ifpm_mono import ifpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pix_t      pix_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mono_vec_t mono_o
);

  localparam int unsigned NSTG = 4;

  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG:0]   rdy;

  // stage payloads
  logic [PIX_W-1:0] ua_q, va_q;
  logic [PIX_W-1:0] ub_q, vb_q, u2b_q, v2b_q, uvb_q;
  logic [PIX_W-1:0] uc_q, vc_q, u2c_q, v2c_q, uvc_q;
  logic [PIX_W-1:0] u3c_q, v3c_q, u2vc_q, uv2c_q, u2v2c_q;
  mono_vec_t        mono_q, mono_d;

  // ready chain: a stage takes a new item when empty or draining
  always_comb begin
    rdy[NSTG] = !out_stall_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // last stage: fourth-degree terms, everything else passed along
  always_comb begin
    mono_d         = '0;
    mono_d[M_ONE]  = ONE_Q15;
    mono_d[M_U]    = MONO_W'(uc_q);
    mono_d[M_V]    = MONO_W'(vc_q);
    mono_d[M_U2]   = MONO_W'(u2c_q);
    mono_d[M_UV]   = MONO_W'(uvc_q);
    mono_d[M_V2]   = MONO_W'(v2c_q);
    mono_d[M_U3]   = MONO_W'(u3c_q);
    mono_d[M_U2V]  = MONO_W'(u2vc_q);
    mono_d[M_UV2]  = MONO_W'(uv2c_q);
    mono_d[M_V3]   = MONO_W'(v3c_q);
    mono_d[M_U4]   = MONO_W'(qmul(u3c_q, uc_q));
    mono_d[M_U3V]  = MONO_W'(qmul(u3c_q, vc_q));
    mono_d[M_U2V2] = MONO_W'(u2v2c_q);
    mono_d[M_UV3]  = MONO_W'(qmul(uc_q, v3c_q));
    mono_d[M_V4]   = MONO_W'(qmul(v3c_q, vc_q));
  end

  // payload registers, loaded whenever the stage is ready
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ua_q <= pix_i.pixel_x;
      va_q <= pix_i.pixel_y;
    end
    if (rdy[1]) begin
      ub_q  <= ua_q;
      vb_q  <= va_q;
      u2b_q <= qmul(ua_q, ua_q);
      v2b_q <= qmul(va_q, va_q);
      uvb_q <= qmul(ua_q, va_q);
    end
    if (rdy[2]) begin
      uc_q    <= ub_q;
      vc_q    <= vb_q;
      u2c_q   <= u2b_q;
      v2c_q   <= v2b_q;
      uvc_q   <= uvb_q;
      u3c_q   <= qmul(u2b_q, ub_q);
      v3c_q   <= qmul(v2b_q, vb_q);
      u2vc_q  <= qmul(u2b_q, vb_q);
      uv2c_q  <= qmul(ub_q, v2b_q);
      u2v2c_q <= qmul(u2b_q, v2b_q);
    end
    if (rdy[3]) begin
      mono_q <= mono_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign mono_o      = mono_q;

  // an accepted item lands in the first stage
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted item did not enter first stage");

  // powers of a value below one never grow
  a_power_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mono_o[M_U2] <= mono_o[M_U]) && (mono_o[M_V2] <= mono_o[M_V])
                 && (mono_o[M_U4] <= mono_o[M_U3]) && (mono_o[M_V4] <= mono_o[M_V3]))
    else $error("monomial power grew");

endmodule

@@ src/ifpm_dot.sv @@
// ----------------------------------------------------------------------------
// ifpm_dot: coefficient dot products
// One stage of 30 constant-coefficient multiplies, then a registered adder
// tree of groups of four, giving the exact Q.35 sums for both axes.
// ----------------------------------------------------------------------------
module ifpm_dot import ifpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mono_vec_t mono_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output acc_pair_t acc_o
);

  localparam int unsigned NSTG = 3;
  localparam int unsigned GRP  = 4;
  localparam int unsigned NGRP = (NUM_TERMS + GRP - 1) / GRP;
  localparam int unsigned FULL_W = MONO_W + COEF_W + 1;

  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG:0]   rdy;

  logic signed [PROD_W-1:0] prod_x_q [NUM_TERMS];
  logic signed [PROD_W-1:0] prod_y_q [NUM_TERMS];
  logic signed [PROD_W-1:0] prod_x_d [NUM_TERMS];
  logic signed [PROD_W-1:0] prod_y_d [NUM_TERMS];
  acc_t grp_x_q [NGRP];
  acc_t grp_y_q [NGRP];
  acc_t grp_x_d [NGRP];
  acc_t grp_y_d [NGRP];
  acc_pair_t acc_q, acc_d;

  // ready chain
  always_comb begin
    rdy[NSTG] = !out_stall_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // monomial times coefficient, one multiply per term and axis
  always_comb begin
    logic signed [FULL_W-1:0] full_x;
    logic signed [FULL_W-1:0] full_y;
    for (int i = 0; i < NUM_TERMS; i++) begin
      full_x      = $signed({1'b0, mono_i[i]}) * COEF_X[i];
      full_y      = $signed({1'b0, mono_i[i]}) * COEF_Y[i];
      prod_x_d[i] = full_x[PROD_W-1:0];
      prod_y_d[i] = full_y[PROD_W-1:0];
    end
  end

  // first tree level: partial sums over groups of four
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_x_d[g] = '0;
      grp_y_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < NUM_TERMS) begin
          grp_x_d[g] = grp_x_d[g] + ACC_W'(prod_x_q[g*GRP+j]);
          grp_y_d[g] = grp_y_d[g] + ACC_W'(prod_y_q[g*GRP+j]);
        end
      end
    end
  end

  // second tree level: total
  always_comb begin
    acc_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      acc_d.acc_x = acc_d.acc_x + grp_x_q[g];
      acc_d.acc_y = acc_d.acc_y + grp_y_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (rdy[1]) begin
      grp_x_q <= grp_x_d;
      grp_y_q <= grp_y_d;
    end
    if (rdy[2]) begin
      acc_q <= acc_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign acc_o       = acc_q;

endmodule

@@ src/ifpm_sat.sv @@
// ----------------------------------------------------------------------------
// ifpm_sat: rounding and saturation
// Rounds the Q.35 sums to Q3.16 (half toward plus infinity), clamps to the
// 20-bit range and holds the result in the output register.
// ----------------------------------------------------------------------------
module ifpm_sat import ifpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  acc_pair_t acc_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output flr_t      flr_o
);

  localparam int unsigned QW = ACC_W - FRAC_DROP;
  localparam acc_t RND = ACC_W'(2**(FRAC_DROP-1));
  localparam logic signed [QW-1:0] Q_MAX = QW'(2**(OUT_W-1) - 1);
  localparam logic signed [QW-1:0] Q_MIN = ~Q_MAX;
  localparam logic signed [OUT_W-1:0] O_MAX = OUT_W'(2**(OUT_W-1) - 1);
  localparam logic signed [OUT_W-1:0] O_MIN = ~O_MAX;

  logic vld_q;
  logic rdy;
  flr_t flr_q, flr_d;

  function automatic logic signed [OUT_W-1:0] round_sat(input acc_t acc);
    acc_t t;
    logic signed [QW-1:0] q;
    t = acc + RND;
    q = t[ACC_W-1:FRAC_DROP];
    if (q > Q_MAX) begin
      return O_MAX;
    end else if (q < Q_MIN) begin
      return O_MIN;
    end else begin
      return q[OUT_W-1:0];
    end
  endfunction

  assign rdy = !vld_q || !out_stall_i;

  always_comb begin
    flr_d.floor_x = round_sat(acc_i.acc_x);
    flr_d.floor_y = round_sat(acc_i.acc_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      flr_q <= flr_d;
    end
  end

  assign in_stall_o  = !rdy;
  assign out_valid_o = vld_q;
  assign flr_o       = flr_q;

endmodule

@@ src/image_to_floor_poly_map.sv @@
// ----------------------------------------------------------------------------
// image_to_floor_poly_map: camera pixel to floor plane position
// Degree-four bivariate polynomial calibration in fixed point.
// ----------------------------------------------------------------------------
// Takes a pixel position (unsigned Q11.4, read as Q0.15 after the divide by
// 2048) and returns the floor position in metres as signed Q3.16, rounded
// half up and saturated. One item enters per cycle and one result leaves per
// cycle while the output is not stalled. An input register and three stages
// of Q0.15 multiplies build the 15 monomials, one stage multiplies them by
// the constant coefficients, two adder-tree stages sum them, and the last
// stage rounds, clamps and holds the result. Stalls back up stage by stage,
// and empty stages fill while the output waits. No state is kept between
// items.
module image_to_floor_poly_map import ifpm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  pix_t pix_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output flr_t flr_o
);

  logic      mono_valid, mono_stall;
  mono_vec_t mono;
  logic      acc_valid, acc_stall;
  acc_pair_t acc;

  // monomials
  ifpm_mono u_mono (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pix_i      (pix_i),
    .out_valid_o(mono_valid),
    .out_stall_i(mono_stall),
    .mono_o     (mono)
  );

  // dot products
  ifpm_dot u_dot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mono_valid),
    .in_stall_o (mono_stall),
    .mono_i     (mono),
    .out_valid_o(acc_valid),
    .out_stall_i(acc_stall),
    .acc_o      (acc)
  );

  // round, clamp, output register
  ifpm_sat u_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (acc_valid),
    .in_stall_o (acc_stall),
    .acc_i      (acc),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .flr_o      (flr_o)
  );

  // the input only stalls when a result is waiting at a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

@@ verif/tb_image_to_floor_poly_map.sv @@
// ----------------------------------------------------------------------------
// tb_image_to_floor_poly_map: self-checking bench for the pixel to floor map
// Sends directed corner pixels, then random ones, under changing input gaps
// and output stalls. Each result is checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_image_to_floor_poly_map;
  import ifpm_pkg::*;

  localparam int unsigned N_RANDOM    = 1150;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 24;
  localparam longint      FLOOR_MAX   = 524287;
  localparam longint      FLOOR_MIN   = -524288;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // idle percentages per traffic mode: none, sender gaps, receiver stalls, both
  localparam int unsigned GAP_PCT   [4] = '{0, 49, 0, 38};
  localparam int unsigned STALL_PCT [4] = '{0, 0, 49, 38};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_t pix = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  flr_t flr;

  pix_t pending_pix [$];
  flr_t floor_due   [$];
  pix_t next_pix;

  int unsigned sent_cnt    = 0;
  int unsigned checked_cnt = 0;
  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned traffic_mode;

  image_to_floor_poly_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pix_i       (pix),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .flr_o       (flr)
  );

  // 20-unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // traffic mode rotates every 64 items
  assign traffic_mode = (sent_cnt >> 6) % 4;

  // Q0.15 product, round half up
  function automatic longint q15_product(input longint a, input longint b);
    return (a * b + 16384) >>> 15;
  endfunction

  // Q.35 sum to Q3.16, round half up, clamp
  function automatic logic signed [OUT_W-1:0] to_metres(input longint acc);
    longint q;
    q = (acc + 262144) >>> FRAC_DROP;
    if (q > FLOOR_MAX) q = FLOOR_MAX;
    if (q < FLOOR_MIN) q = FLOOR_MIN;
    return OUT_W'(q);
  endfunction

  // floor position predicted for one pixel
  function automatic flr_t map_pixel(input pix_t p);
    longint u, v, u2, u3, u4, v2, v3, v4;
    longint term [NUM_TERMS];
    longint sum_x, sum_y;
    flr_t f;
    u  = longint'(p.pixel_x);
    v  = longint'(p.pixel_y);
    u2 = q15_product(u, u);
    u3 = q15_product(u2, u);
    u4 = q15_product(u3, u);
    v2 = q15_product(v, v);
    v3 = q15_product(v2, v);
    v4 = q15_product(v3, v);
    term[M_ONE]  = 32768;
    term[M_U]    = u;
    term[M_V]    = v;
    term[M_U2]   = u2;
    term[M_UV]   = q15_product(u, v);
    term[M_V2]   = v2;
    term[M_U3]   = u3;
    term[M_U2V]  = q15_product(u2, v);
    term[M_UV2]  = q15_product(u, v2);
    term[M_V3]   = v3;
    term[M_U4]   = u4;
    term[M_U3V]  = q15_product(u3, v);
    term[M_U2V2] = q15_product(u2, v2);
    term[M_UV3]  = q15_product(u, v3);
    term[M_V4]   = v4;
    sum_x = 0;
    sum_y = 0;
    for (int i = 0; i < NUM_TERMS; i++) begin
      sum_x += term[i] * longint'(COEF_X[i]);
      sum_y += term[i] * longint'(COEF_Y[i]);
    end
    f.floor_x = to_metres(sum_x);
    f.floor_y = to_metres(sum_y);
    return f;
  endfunction

  // random coordinate, leaning toward the edges now and then
  function automatic logic [PIX_W-1:0] random_coord();
    case ($urandom_range(9))
      0: return PIX_W'($urandom_range(3));
      1: return PIX_MAX - PIX_W'($urandom_range(3));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // driver: launches pending items, holds them while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      pix      <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending_pix.size() != 0 &&
          $urandom_range(99) >= GAP_PCT[traffic_mode]) begin
        next_pix = pending_pix.pop_front();
        floor_due.push_back(map_pixel(next_pix));
        in_valid <= 1'b1;
        pix      <= next_pix;
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks accepted results, drives output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (floor_due.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d", $time,
                   flr.floor_x, flr.floor_y);
          err_cnt++;
        end else begin
          if (flr.floor_x !== floor_due[0].floor_x) begin
            $display("%0t: floor_x mismatch: expected %0d, actual %0d", $time,
                     floor_due[0].floor_x, flr.floor_x);
            err_cnt++;
          end
          if (flr.floor_y !== floor_due[0].floor_y) begin
            $display("%0t: floor_y mismatch: expected %0d, actual %0d", $time,
                     floor_due[0].floor_y, flr.floor_y);
            err_cnt++;
          end
          void'(floor_due.pop_front());
          checked_cnt++;
        end
      end
      out_stall <= ($urandom_range(99) < STALL_PCT[traffic_mode]);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               floor_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    pix_t p;
    // corners and edges of the pixel range
    pending_pix.push_back('{pixel_x: '0,      pixel_y: '0});
    pending_pix.push_back('{pixel_x: PIX_MAX, pixel_y: PIX_MAX});
    pending_pix.push_back('{pixel_x: '0,      pixel_y: PIX_MAX});
    pending_pix.push_back('{pixel_x: PIX_MAX, pixel_y: '0});
    pending_pix.push_back('{pixel_x: 15'd1,   pixel_y: 15'd1});
    pending_pix.push_back('{pixel_x: 15'd1,   pixel_y: PIX_MAX});
    pending_pix.push_back('{pixel_x: PIX_MAX, pixel_y: 15'd1});
    pending_pix.push_back('{pixel_x: 15'h4000, pixel_y: 15'h4000});
    pending_pix.push_back('{pixel_x: 15'h3FFF, pixel_y: 15'h4000});
    pending_pix.push_back('{pixel_x: 15'h2AAA, pixel_y: 15'h5555});
    pending_pix.push_back('{pixel_x: 15'h5555, pixel_y: 15'h2AAA});
    pending_pix.push_back('{pixel_x: 15'h7FFE, pixel_y: 15'h0001});
    // rounding half-way points of the squares
    pending_pix.push_back('{pixel_x: 15'h0080, pixel_y: 15'h0180});
    // walking ones on the even bit positions of each coordinate
    for (int b = 0; b < PIX_W; b += 2) begin
      pending_pix.push_back('{pixel_x: PIX_W'(1) << b, pixel_y: PIX_W'(1) << (PIX_W-1-b)});
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      p.pixel_x = random_coord();
      p.pixel_y = random_coord();
      pending_pix.push_back(p);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pix.size() != 0 || in_valid || floor_due.size() != 0)
      @(posedge clk_i);
    // catch any stray result after the last one
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d pixels (directed corners plus random), checked %0d floor points",
             sent_cnt, checked_cnt);
    $display("traffic rotated through back-to-back, input gaps, output stalls and both");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ image_to_floor_poly_map.f @@
src/ifpm_pkg.sv
src/ifpm_mono.sv
src/ifpm_dot.sv
src/ifpm_sat.sv
src/image_to_floor_poly_map.sv
verif/tb_image_to_floor_poly_map.sv
